@@ rtl/core/cdsm_pkg.sv @@
// Shared types, constants and digit functions of the countdown display core.
package cdsm_pkg;

   // Largest loadable count, 99:59
   localparam logic [12:0] MaxSeconds = 13'd5999;

   // Reciprocal of 60 scaled by 2**19; exact quotient for counts below 6000
   localparam logic [26:0] RecipSixty = 27'd8739;
   localparam int          RecipShift = 19;

   // Reciprocal of 10 scaled by 2**11; exact quotient for values below 1029
   localparam logic [17:0] RecipTen   = 18'd205;
   localparam int          TenShift   = 11;

   // Segment patterns gfedcba for digits 0..9
   localparam logic [9:0][6:0] SegTable = '{
      7'b1101111, 7'b1111111, 7'b0000111, 7'b1111101, 7'b1101101,
      7'b1100110, 7'b1001111, 7'b1011011, 7'b0000110, 7'b0111111
   };

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_START   = 2'd1,
      OP_TICK    = 2'd2,
      OP_REFRESH = 2'd3
   } op_type;

   // Index 0 is tens of minutes, then units of minutes, tens and units of seconds
   typedef logic [3:0][3:0] digits_type;

   typedef struct packed {
      op_type      op;
      logic [12:0] load_seconds;
   } req_type;

   typedef struct packed {
      logic [6:0]  segments;
      logic [3:0]  digit_enable;
      logic [12:0] remaining;
      logic        running;
      logic        finished;
   } rsp_type;

   // Blank any code outside 0..9
   function automatic logic [6:0] seg_of(input logic [3:0] code);
      logic [6:0] pattern;
      pattern = 7'd0;
      if (code < 4'd10) begin
         pattern = SegTable[code];
      end
      return pattern;
   endfunction

   // Split a value below 100 into tens and units
   function automatic logic [7:0] split_tens(input logic [6:0] value);
      logic [17:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  units;
      prod     = {11'd0, value} * RecipTen;
      tens     = prod[TenShift+3:TenShift];
      tens_x10 = {3'd0, tens} * 7'd10;
      units    = value - tens_x10;
      return {tens, units[3:0]};
   endfunction

   // Split a count of seconds below 6000 into mm:ss digits
   function automatic digits_type split_digits(input logic [12:0] total);
      logic [26:0] prod;
      logic [6:0]  mins;
      logic [12:0] mins_x60;
      logic [12:0] rem_secs;
      logic [7:0]  min_pair;
      logic [7:0]  sec_pair;
      digits_type  digits;
      prod     = {14'd0, total} * RecipSixty;
      mins     = prod[RecipShift+6:RecipShift];
      mins_x60 = {6'd0, mins} * 13'd60;
      rem_secs = total - mins_x60;
      min_pair = split_tens(mins);
      sec_pair = split_tens({1'b0, rem_secs[5:0]});
      digits[0] = min_pair[7:4];
      digits[1] = min_pair[3:0];
      digits[2] = sec_pair[7:4];
      digits[3] = sec_pair[3:0];
      return digits;
   endfunction

endpackage

@@ rtl/core/countdown_seven_segment_mux_core.sv @@
// Top level: mm:ss countdown with multiplexed seven-segment digit scan.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_payload (op, load_seconds)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_payload (segments .. finished)
//
// Every request gives one response; the state update and the response are
// formed in the cycle the request is accepted. The state update shows up in
// the next cycle. A new request is taken every cycle while responses drain;
// the two-entry result buffer keeps ready high on a stall until its skid stage fills.
// Synchronous reset clears the count, the digits, the scan position and
// the displayed pattern and enable.
module countdown_seven_segment_mux_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdsm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdsm_pkg::rsp_type rsp_payload
);
   import cdsm_pkg::*;

   logic [12:0] seconds_ff, seconds_in;
   digits_type  digits_ff, digits_in;
   logic [1:0]  scan_ff, scan_in;
   logic        counting_ff, counting_in;
   logic        loaded_ff, loaded_in;
   logic [6:0]  pattern_ff, pattern_in;
   logic [3:0]  enable_ff, enable_in;
   logic        finished_in;
   logic [12:0] load_sat;
   logic        req_fire;
   rsp_type     rsp_next;

   assign req_fire = req_valid && req_ready;
   assign load_sat = (req_payload.load_seconds > MaxSeconds) ? MaxSeconds
                                                             : req_payload.load_seconds;

   // Compute the next state for the current transaction
   always_comb begin
      seconds_in  = seconds_ff;
      digits_in   = digits_ff;
      scan_in     = scan_ff;
      counting_in = counting_ff;
      loaded_in   = loaded_ff;
      pattern_in  = pattern_ff;
      enable_in   = enable_ff;
      finished_in = 1'b0;
      case (req_payload.op)
         OP_LOAD: begin
            if (!counting_ff) begin
               seconds_in = load_sat;
               digits_in  = split_digits(load_sat);
               loaded_in  = 1'b1;
            end
         end
         OP_START: begin
            if (loaded_ff) begin
               counting_in = 1'b1;
            end
         end
         OP_TICK: begin
            if (counting_ff) begin
               if (seconds_ff != 13'd0) begin
                  seconds_in = seconds_ff - 13'd1;
                  digits_in  = split_digits(seconds_ff - 13'd1);
               end else begin
                  counting_in = 1'b0;
                  finished_in = 1'b1;
               end
            end
         end
         OP_REFRESH: begin
            enable_in  = 4'b0001 << scan_ff;
            pattern_in = seg_of(digits_ff[scan_ff]);
            scan_in    = scan_ff + 2'd1;
         end
         default: begin
            finished_in = 1'b0;
         end
      endcase
   end

   // Hold state until a transaction is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff  <= 13'd0;
         digits_ff   <= '0;
         scan_ff     <= 2'd0;
         counting_ff <= 1'b0;
         loaded_ff   <= 1'b0;
         pattern_ff  <= 7'd0;
         enable_ff   <= 4'd0;
      end else if (req_fire) begin
         seconds_ff  <= seconds_in;
         digits_ff   <= digits_in;
         scan_ff     <= scan_in;
         counting_ff <= counting_in;
         loaded_ff   <= loaded_in;
         pattern_ff  <= pattern_in;
         enable_ff   <= enable_in;
      end
   end

   // Form the response from the updated state
   always_comb begin
      rsp_next.segments     = pattern_in;
      rsp_next.digit_enable = enable_in;
      rsp_next.remaining    = seconds_in;
      rsp_next.running      = counting_in;
      rsp_next.finished     = finished_in;
   end

   cdsm_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (rsp_next),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   // A count can only run once a time has been loaded
   assert property (@(posedge clock) disable iff (reset) counting_ff |-> loaded_ff)
      else $error("count running without a loaded time");

   // The finishing tick always stops the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.finished && rsp_payload.running))
      else $error("finished reported while still running");

   // Remaining time never exceeds the saturation limit
   assert property (@(posedge clock) disable iff (reset) seconds_ff <= MaxSeconds)
      else $error("remaining seconds above limit");

   // At most one digit is enabled at a time
   assert property (@(posedge clock) disable iff (reset) $onehot0(enable_ff))
      else $error("more than one digit enabled");

endmodule

@@ rtl/core/cdsm_rsp_buffer.sv @@
// Result register with a skid stage between the core and the result channel.
module cdsm_rsp_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cdsm_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cdsm_pkg::rsp_type out_data
);
   import cdsm_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_data_ff;
   rsp_type skid_data_ff;

   // Take a new transaction whenever the skid stage is free
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // Advance the main register, park a transaction in the skid stage on a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_valid;
         end
      end else if (in_valid && in_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      if (out_ready || !main_valid_ff) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid && in_ready) begin
         skid_data_ff <= in_data;
      end
   end

endmodule
